### rtl/ttor_pkg.sv
// ----------------------------------------------------------------------------
// ttor_pkg: shared types and constants of the tick timer one-shot replay unit
// Event codes, item and result structures, reload helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ttor_pkg;

    // number of motor byte lanes carried by one item
    localparam int unsigned TTOR_IN_CH          = 6;
    // default number of stored replay lanes
    localparam int unsigned TTOR_MOTOR_CHANNELS = 6;

    localparam int unsigned TTOR_CNT_W  = 16;
    localparam int unsigned TTOR_HALF_W = 31;
    localparam int unsigned TTOR_BYTE_W = 8;

    // event codes carried in tuser
    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_ONESHOT = 3'd1,
        FUNC_POST    = 3'd2,
        FUNC_SAVE    = 3'd3,
        FUNC_RESTORE = 3'd4
    } func_t;

    typedef logic [TTOR_IN_CH-1:0][TTOR_BYTE_W-1:0] lanes_t;

    // one accepted input item
    typedef struct packed {
        func_t                 func;
        logic [TTOR_CNT_W-1:0] duration_ms;
        lanes_t                motor;
    } item_t;

    // one result item
    typedef struct packed {
        logic [TTOR_HALF_W-1:0] now_half;
        logic                   expired;
        logic                   running;
        logic                   step_fired;
        lanes_t                 out_val;
    } result_t;

    // reload value for a length in ms: low 16 bits of 2*ms-1
    function automatic logic [TTOR_CNT_W-1:0] ms_to_reload(input logic [TTOR_CNT_W-1:0] ms);
        return {ms[TTOR_CNT_W-2:0], 1'b0} - {{(TTOR_CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

### rtl/tick_timer_oneshot_replay_unit.sv
// ----------------------------------------------------------------------------
// tick_timer_oneshot_replay_unit: half-millisecond time base with one-shot
// Free-running or one-shot 16-bit tick counter with a one-step replay buffer.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                              | tuser
//  s_       | in        | duration_ms, motor_a..motor_f      | func
//  m_       | out       | now_half, expired, running, out_*  | step_fired
//
//  One item per cycle sustained while m_ takes results; an item is held in the
//  input register and then in the result register, from which m_ presents
//  its result. Each event is applied to the timer state between the two
//  registers, as the result register loads; the state update is the only loop.
//  Reset (aresetn low, synchronous) clears both stages and sets the timer to
//  free run, counter and overflow word zero.
//  A stall on m_ holds the result register and then the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_timer_oneshot_replay_unit
    import ttor_pkg::*;
#(
    parameter int unsigned MOTOR_CHANNELS = TTOR_MOTOR_CHANNELS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // duration_ms[15:0], motor_a[23:16], motor_b[31:24], motor_c[39:32],
    // motor_d[47:40], motor_e[55:48], motor_f[63:56]
    input  wire logic [63:0] s_tdata,
    // func[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // now_half[30:0], expired[31], running[32], out_a[40:33], out_b[48:41],
    // out_c[56:49], out_d[64:57], out_e[72:65], out_f[80:73], zero[87:81]
    output logic [87:0]      m_tdata,
    // step_fired[0]
    output logic [0:0]       m_tuser
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    fire;
    result_t result;
    result_t out_result;

    // unpack the incoming transfer
    assign in_item.func        = func_t'(s_tuser);
    assign in_item.duration_ms = s_tdata[15:0];
    for (genvar g = 0; g < TTOR_IN_CH; g++) begin : g_unpack
        assign in_item.motor[g] = s_tdata[16 + g*TTOR_BYTE_W +: TTOR_BYTE_W];
    end

    ttor_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    assign fire = item_valid && advance;

    ttor_core #(
        .MOTOR_CHANNELS (MOTOR_CHANNELS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_item (item),
        .result  (result)
    );

    ttor_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // pack the outgoing transfer
    assign m_tdata[30:0]  = out_result.now_half;
    assign m_tdata[31]    = out_result.expired;
    assign m_tdata[32]    = out_result.running;
    for (genvar g = 0; g < TTOR_IN_CH; g++) begin : g_pack
        assign m_tdata[33 + g*TTOR_BYTE_W +: TTOR_BYTE_W] = out_result.out_val[g];
    end
    assign m_tdata[87:81] = '0;
    assign m_tuser[0]     = out_result.step_fired;

endmodule

`default_nettype wire

### rtl/ttor_in_stage.sv
// ----------------------------------------------------------------------------
// ttor_in_stage: input register
// Holds one accepted item until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ttor_in_stage
    import ttor_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // take a new transfer when empty or when the held item moves on
    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### rtl/ttor_core.sv
// ----------------------------------------------------------------------------
// ttor_core: timer state and event handling
// Applies one event per cycle, while fire is high, to the timer state and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module ttor_core
    import ttor_pkg::*;
#(
    parameter int unsigned MOTOR_CHANNELS = TTOR_MOTOR_CHANNELS
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  fire,
    input  wire item_t in_item,
    output result_t    result
);

    localparam int unsigned MOTOR_LANES =
        (MOTOR_CHANNELS < TTOR_IN_CH) ? MOTOR_CHANNELS : TTOR_IN_CH;

    typedef logic [MOTOR_LANES-1:0][TTOR_BYTE_W-1:0] store_t;

    logic [TTOR_CNT_W-1:0] cnt_reg,    cnt_next;
    logic [TTOR_CNT_W-1:0] reload_reg, reload_next;
    logic [TTOR_CNT_W-1:0] ovf_reg,    ovf_next;
    logic                  en_reg,      en_next;
    logic                  oneshot_reg, oneshot_next;
    logic                  expired_reg, expired_next;
    logic                  pend_reg,    pend_next;
    store_t                pvals_reg,   pvals_next;
    logic [TTOR_CNT_W-1:0] pdur_reg,    pdur_next;
    logic [TTOR_CNT_W-1:0] sovf_reg,    sovf_next;
    logic [TTOR_CNT_W-1:0] scnt_reg,    scnt_next;
    logic                  sen_reg,     sen_next;
    logic                  fired;
    logic [TTOR_CNT_W-1:0] step_len;

    // a step length of zero counts as one
    assign step_len = (pdur_reg == '0) ? {{(TTOR_CNT_W-1){1'b0}}, 1'b1} : pdur_reg;

    // event decode and next state
    always_comb begin
        cnt_next     = cnt_reg;
        reload_next  = reload_reg;
        ovf_next     = ovf_reg;
        en_next      = en_reg;
        oneshot_next = oneshot_reg;
        expired_next = expired_reg;
        pend_next    = pend_reg;
        pvals_next   = pvals_reg;
        pdur_next    = pdur_reg;
        sovf_next    = sovf_reg;
        scnt_next    = scnt_reg;
        sen_next     = sen_reg;
        fired        = 1'b0;
        if (fire) begin
            unique case (in_item.func)
                FUNC_TICK: begin
                    if (en_reg) begin
                        if (cnt_reg == reload_reg) begin
                            cnt_next = '0;
                            if (oneshot_reg) begin
                                if (pend_reg) begin
                                    fired        = 1'b1;
                                    reload_next  = ms_to_reload(step_len);
                                    expired_next = 1'b0;
                                    en_next      = 1'b1;
                                    pend_next    = 1'b0;
                                end else begin
                                    expired_next = 1'b1;
                                    oneshot_next = 1'b0;
                                    en_next      = 1'b0;
                                end
                            end else begin
                                ovf_next = ovf_reg + {{(TTOR_CNT_W-1){1'b0}}, 1'b1};
                            end
                        end else begin
                            cnt_next = cnt_reg + {{(TTOR_CNT_W-1){1'b0}}, 1'b1};
                        end
                    end
                end
                FUNC_ONESHOT: begin
                    cnt_next     = '0;
                    ovf_next     = '0;
                    reload_next  = ms_to_reload(in_item.duration_ms);
                    expired_next = 1'b0;
                    oneshot_next = 1'b1;
                    en_next      = 1'b1;
                end
                FUNC_POST: begin
                    for (int i = 0; i < MOTOR_LANES; i++) begin
                        pvals_next[i] = in_item.motor[i];
                    end
                    pdur_next = in_item.duration_ms;
                    pend_next = 1'b1;
                end
                FUNC_SAVE: begin
                    sovf_next = ovf_reg;
                    scnt_next = cnt_reg;
                    sen_next  = en_reg;
                end
                FUNC_RESTORE: begin
                    reload_next  = '1;
                    cnt_next     = scnt_reg;
                    ovf_next     = sovf_reg;
                    oneshot_next = 1'b0;
                    expired_next = 1'b0;
                    en_next      = sen_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            reload_reg  <= '1;
            ovf_reg     <= '0;
            en_reg      <= 1'b1;
            oneshot_reg <= 1'b0;
            expired_reg <= 1'b0;
            pend_reg    <= 1'b0;
            pvals_reg   <= '0;
            pdur_reg    <= '0;
            sovf_reg    <= '0;
            scnt_reg    <= '0;
            sen_reg     <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            reload_reg  <= reload_next;
            ovf_reg     <= ovf_next;
            en_reg      <= en_next;
            oneshot_reg <= oneshot_next;
            expired_reg <= expired_next;
            pend_reg    <= pend_next;
            pvals_reg   <= pvals_next;
            pdur_reg    <= pdur_next;
            sovf_reg    <= sovf_next;
            scnt_reg    <= scnt_next;
            sen_reg     <= sen_next;
        end
    end

    // result reflects the state after the event
    assign result.now_half   = {ovf_next, cnt_next[TTOR_CNT_W-1:1]};
    assign result.expired    = expired_next;
    assign result.running    = en_next;
    assign result.step_fired = fired;

    // emitted lanes, zero when no step fires or beyond the stored lanes
    for (genvar g = 0; g < TTOR_IN_CH; g++) begin : g_lane
        if (g < MOTOR_LANES) begin : g_used
            assign result.out_val[g] = fired ? pvals_reg[g] : '0;
        end else begin : g_unused
            assign result.out_val[g] = '0;
        end
    end

`ifndef SYNTH
    // an expired one-shot leaves the counter stopped
    a_expired_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        expired_reg |-> (!en_reg && !oneshot_reg))
        else $error("expired flag set while counter runs");

    // a step only fires on a tick in one-shot mode with a step pending
    a_fire_source: assert property (@(posedge aclk) disable iff (!aresetn)
        fired |-> (fire && in_item.func == FUNC_TICK && oneshot_reg && pend_reg))
        else $error("step fired outside a one-shot expiry");

    // a fired step is consumed
    a_fire_consumes: assert property (@(posedge aclk) disable iff (!aresetn)
        fired |=> !pend_reg)
        else $error("step still pending after firing");

    // the overflow word stays clear during a one-shot
    a_oneshot_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        oneshot_reg |-> (ovf_reg == '0))
        else $error("overflow word moved in one-shot mode");
`endif

endmodule

`default_nettype wire

### rtl/ttor_out_stage.sv
// ----------------------------------------------------------------------------
// ttor_out_stage: result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ttor_out_stage
    import ttor_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    item_valid,
    input  wire result_t result,
    output logic         advance,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // the register may be loaded when empty or being emptied
    assign advance = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire
